// ===== hw/rtl/transposition_table_lookup_top_assert.svh =====
// Assertion macros used by the transposition table RTL.
`ifndef TRANSPOSITION_TABLE_LOOKUP_TOP_ASSERT_SVH
`define TRANSPOSITION_TABLE_LOOKUP_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TTL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TTL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/ttl_pkg.sv =====
// Types and constants of the transposition table lookup block.
package ttl_pkg;

	localparam int TABLE_ENTRIES = 65536;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int SLOT_W        = IDX_W + 1;
	localparam int SLOT_COUNT    = 2 * TABLE_ENTRIES;
	localparam int HASH_W        = 64;
	localparam int LOCK_W        = HASH_W - IDX_W;
	localparam int POS_W         = 11;
	localparam int SANITY_W      = 2 * POS_W;
	localparam int SCORE_W       = 32;
	localparam int FLAG_W        = 2;
	localparam int DEPTH_W       = 6;

	typedef enum logic {
		REQ_STORE    = 1'b0,
		REQ_RETRIEVE = 1'b1
	} req_type_t;

	typedef struct packed {
		logic [LOCK_W-1:0]   lock;
		logic [SANITY_W-1:0] sanity;
		logic [SCORE_W-1:0]  score;
		logic [FLAG_W-1:0]   flag;
		logic [DEPTH_W-1:0]  depth;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic              busy;
		logic [SLOT_W-1:0] addr;
	} clear_t;

endpackage

// ===== hw/rtl/ttl_req_if.sv =====
// Request channel of the transposition table lookup block.
interface ttl_req_if;
	import ttl_pkg::*;

	logic                     valid;
	logic                     ready;
	req_type_t                req_type;
	logic [HASH_W-1:0]        position_hash;
	logic                     player;
	logic signed [POS_W-1:0]  dark_queen_pos;
	logic signed [POS_W-1:0]  light_queen_pos;
	logic [SCORE_W-1:0]       score_bits;
	logic [FLAG_W-1:0]        bound_flag;
	logic [DEPTH_W-1:0]       search_depth;

	modport source (
		output valid, req_type, position_hash, player, dark_queen_pos, light_queen_pos,
		       score_bits, bound_flag, search_depth,
		input  ready
	);

	modport sink (
		input  valid, req_type, position_hash, player, dark_queen_pos, light_queen_pos,
		       score_bits, bound_flag, search_depth,
		output ready
	);

endinterface

// ===== hw/rtl/ttl_rsp_if.sv =====
// Result channel of the transposition table lookup block.
interface ttl_rsp_if;
	import ttl_pkg::*;

	logic                 valid;
	logic                 ready;
	logic                 hit;
	logic [SCORE_W-1:0]   found_score;
	logic [FLAG_W-1:0]    found_flag;
	logic [DEPTH_W-1:0]   found_depth;

	modport source (
		output valid, hit, found_score, found_flag, found_depth,
		input  ready
	);

	modport sink (
		input  valid, hit, found_score, found_flag, found_depth,
		output ready
	);

endinterface

// ===== hw/rtl/ttl_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
module ttl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             en,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en && we) begin
			mem_q[addr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (en && !we) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

// ===== hw/rtl/ttl_clear.sv =====
// Sweep that clears every valid bit once after reset.
module ttl_clear (
	input  logic            clk,
	input  logic            arst_n,
	output ttl_pkg::clear_t clr
);
	import ttl_pkg::*;

	logic              busy_q;
	logic [SLOT_W-1:0] addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			addr_q <= '0;
		end else if (busy_q) begin
			addr_q <= addr_q + SLOT_W'(1);
			if (addr_q == SLOT_W'(SLOT_COUNT - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign clr.busy = busy_q;
	assign clr.addr = addr_q;

endmodule

// ===== hw/rtl/transposition_table_lookup_top.sv =====
// Direct-mapped transposition table: top level with the lookup pipeline.
//
// The block takes requests on req and returns retrieve results on rsp. Both
// channels move one request when valid and ready are high at a clock edge.
// A store overwrites the slot chosen by the hash and the player and gives no
// result. A retrieve gives exactly one result: hit with the stored score,
// bound kind and depth, or a miss with all fields zero.
// One request is taken per cycle while req.ready is high; a retrieve result
// passes through the memory read stage and the output register before it is
// offered on rsp. The pace is set by the single port of the entry memory,
// which serves one read or one write per cycle.
// After reset the valid memory is swept one slot per cycle over all 131072
// slots, while req.ready stays low.
// When the receiver stalls, the output register holds the waiting result and
// one further retrieve can sit in the read stage; with both full, req.ready
// drops until rsp takes the waiting result.
module transposition_table_lookup_top (
	input  logic   clk,
	input  logic   arst_n,
	ttl_req_if.sink   req,
	ttl_rsp_if.source rsp
);
	import ttl_pkg::*;
	`include "transposition_table_lookup_top_assert.svh"

	clear_t              clr;
	logic                acc;
	logic                is_store;
	logic [SLOT_W-1:0]   slot;
	entry_t              wr_entry;
	entry_t              rd_entry;
	logic                rd_valid;
	logic                vram_en;
	logic                vram_we;
	logic [SLOT_W-1:0]   vram_addr;
	logic                vram_wdata;
	logic                s1_valid_s1;
	logic [LOCK_W-1:0]   lock_s1;
	logic [SANITY_W-1:0] sanity_s1;
	logic                s1_adv;
	logic                hit_s1;
	logic                out_valid_q;
	logic                hit_q;
	logic [SCORE_W-1:0]  score_q;
	logic [FLAG_W-1:0]   flag_q;
	logic [DEPTH_W-1:0]  depth_q;

	ttl_clear u_clear (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (clr)
	);

	assign req.ready = !clr.busy && !(s1_valid_s1 && out_valid_q && !rsp.ready);
	assign acc       = req.valid && req.ready;
	assign is_store  = (req.req_type == REQ_STORE);
	assign slot      = {req.player, req.position_hash[IDX_W-1:0]};

	assign wr_entry.lock   = req.position_hash[HASH_W-1:IDX_W];
	assign wr_entry.sanity = {req.dark_queen_pos, req.light_queen_pos};
	assign wr_entry.score  = req.score_bits;
	assign wr_entry.flag   = req.bound_flag;
	assign wr_entry.depth  = req.search_depth;

	assign vram_en    = clr.busy || acc;
	assign vram_we    = clr.busy || (acc && is_store);
	assign vram_addr  = clr.busy ? clr.addr : slot;
	assign vram_wdata = !clr.busy;

	ttl_ram #(
		.WIDTH (1),
		.DEPTH (SLOT_COUNT)
	) u_valid_ram (
		.clk   (clk),
		.en    (vram_en),
		.we    (vram_we),
		.addr  (vram_addr),
		.wdata (vram_wdata),
		.rdata (rd_valid)
	);

	ttl_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (SLOT_COUNT)
	) u_entry_ram (
		.clk   (clk),
		.en    (acc),
		.we    (is_store),
		.addr  (slot),
		.wdata (wr_entry),
		.rdata (rd_entry)
	);

	assign s1_adv = s1_valid_s1 && (!out_valid_q || rsp.ready);
	assign hit_s1 = rd_valid && (rd_entry.lock == lock_s1) && (rd_entry.sanity == sanity_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (acc) begin
			s1_valid_s1 <= !is_store;
		end else if (s1_adv) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			lock_s1   <= wr_entry.lock;
			sanity_s1 <= wr_entry.sanity;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			hit_q   <= hit_s1;
			score_q <= hit_s1 ? rd_entry.score : '0;
			flag_q  <= hit_s1 ? rd_entry.flag : '0;
			depth_q <= hit_s1 ? rd_entry.depth : '0;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.hit         = hit_q;
	assign rsp.found_score = score_q;
	assign rsp.found_flag  = flag_q;
	assign rsp.found_depth = depth_q;

	`TTL_ASSERT_NOW(a_no_req_in_clear, clk, arst_n, req.valid && req.ready, !clr.busy,
		"request taken during the valid sweep")
	`TTL_ASSERT_NEXT(a_retrieve_enters_s1, clk, arst_n,
		req.valid && req.ready && req.req_type == REQ_RETRIEVE, s1_valid_s1,
		"retrieve did not enter the read stage")
	`TTL_ASSERT_NOW(a_miss_is_zero, clk, arst_n, rsp.valid && !rsp.hit,
		rsp.found_score == '0 && rsp.found_flag == '0 && rsp.found_depth == '0,
		"miss result carries nonzero fields")
	`TTL_ASSERT_NOW(a_idle_in_clear, clk, arst_n, clr.busy, !s1_valid_s1 && !rsp.valid,
		"lookup active during the valid sweep")

endmodule
